// ===== sv/ele_pkg.sv =====
`timescale 1ns / 1ps
package ele_pkg;

    localparam int DATA_W    = 8;
    localparam int CNT_W     = 6;
    localparam int POS_W     = 3;
    localparam int M_TDATA_W = 16;

    localparam logic [DATA_W-1:0] CH_BS     = 8'd8;
    localparam logic [DATA_W-1:0] CH_LF     = 8'd10;
    localparam logic [DATA_W-1:0] CH_CR     = 8'd13;
    localparam logic [DATA_W-1:0] CH_RETYPE = 8'd18;
    localparam logic [DATA_W-1:0] CH_KILL   = 8'd21;
    localparam logic [DATA_W-1:0] CH_SP     = 8'd32;
    localparam logic [DATA_W-1:0] CH_X      = 8'd88;
    localparam logic [DATA_W-1:0] CH_DEL    = 8'd127;

    typedef enum logic [2:0] {
        K_CHAR    = 3'd0,
        K_BS      = 3'd1,
        K_RETYPE  = 3'd2,
        K_KILL    = 3'd3,
        K_NEWLINE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data;
    } t_cmd;

    // number of fixed echo bytes that open each command
    function automatic logic [POS_W-1:0] echo_len(input t_kind kind);
        logic [POS_W-1:0] len;
        unique case (kind)
            K_CHAR:    len = POS_W'(1);
            K_BS:      len = POS_W'(3);
            K_RETYPE:  len = POS_W'(2);
            K_KILL:    len = POS_W'(5);
            K_NEWLINE: len = POS_W'(2);
            default:   len = POS_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [DATA_W-1:0] echo_byte(input t_kind kind,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] b;
        unique case (kind) inside
            K_CHAR:    b = data;
            K_BS:      b = (pos == POS_W'(1)) ? CH_SP : CH_BS;
            K_RETYPE,
            K_NEWLINE: b = (pos == '0) ? CH_CR : CH_LF;
            K_KILL:    b = (pos < POS_W'(3)) ? CH_X :
                           (pos == POS_W'(3)) ? CH_CR : CH_LF;
            default:   b = data;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/ele_front.sv =====
`timescale 1ns / 1ps
module ele_front
    import ele_pkg::*;
(
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    t_kind w_kind;

    // classify the received byte
    always_comb begin
        unique case (i_data) inside
            CH_BS, CH_DEL: w_kind = K_BS;
            CH_RETYPE:     w_kind = K_RETYPE;
            CH_KILL:       w_kind = K_KILL;
            CH_LF, CH_CR:  w_kind = K_NEWLINE;
            default:       w_kind = K_CHAR;
        endcase
    end

    // accept while the queue has room; ready is dropped during reset
    assign o_ready    = i_rst_n && !i_q_full;
    assign o_push     = i_valid && o_ready;
    assign o_cmd.kind = w_kind;
    assign o_cmd.data = i_data;

endmodule

// ===== sv/ele_queue.sv =====
`timescale 1ns / 1ps
module ele_queue
    import ele_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_cmd;
    end

endmodule

// ===== sv/ele_back.sv =====
`timescale 1ns / 1ps
module ele_back
    import ele_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_byte,
    output logic              o_is_line,
    output logic [CNT_W-1:0]  o_length,
    output logic              o_last
);

    localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam logic [CNT_W-1:0] MAX_CHARS = CNT_W'(LINE_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ECHO = 3'b010,
        S_LINE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_len, n_len;
    logic               r_is_line, n_is_line;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_nzlen, n_nzlen;

    logic [DATA_W-1:0]  r_mem [LINE_LEN];
    logic [DATA_W-1:0]  r_rd_data;
    logic               w_wr_en;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_line, n_out_line;
    logic [CNT_W-1:0]   r_out_len, n_out_len;
    logic               r_out_last, n_out_last;
    logic               w_load;
    logic               w_adv;
    logic [POS_W-1:0]   w_elen;
    logic               w_body_end;

    assign w_adv      = !r_out_valid || i_ready;
    assign w_elen     = echo_len(r_kind);
    assign w_body_end = (r_idx == r_len - CNT_W'(1));

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_data     = r_data;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_len      = r_len;
        n_is_line  = r_is_line;
        n_count    = r_count;
        n_nzlen    = r_nzlen;
        o_pop      = 1'b0;
        w_wr_en    = 1'b0;
        w_load     = 1'b0;
        n_out_byte = r_out_byte;
        n_out_line = r_out_line;
        n_out_len  = r_out_len;
        n_out_last = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_pos = '0;
                if (i_q_valid) begin
                    o_pop     = 1'b1;
                    n_kind    = i_q_cmd.kind;
                    n_data    = i_q_cmd.data;
                    n_len     = '0;
                    n_is_line = 1'b0;
                    unique case (i_q_cmd.kind)
                        K_BS: begin
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                                if (r_nzlen == r_count) n_nzlen = r_count - CNT_W'(1);
                                n_state = S_ECHO;
                            end
                        end
                        K_CHAR: begin
                            if (r_count < MAX_CHARS) begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (r_nzlen == r_count && i_q_cmd.data != '0)
                                    n_nzlen = r_count + CNT_W'(1);
                                n_state = S_ECHO;
                            end
                        end
                        K_RETYPE: begin
                            n_len   = r_nzlen;
                            n_state = S_ECHO;
                        end
                        K_KILL: begin
                            n_count = '0;
                            n_nzlen = '0;
                            n_state = S_ECHO;
                        end
                        K_NEWLINE: begin
                            n_len     = r_count + CNT_W'(1);
                            n_is_line = 1'b1;
                            n_count   = '0;
                            n_nzlen   = '0;
                            n_state   = S_ECHO;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ECHO: begin
                if (w_adv) begin
                    w_load     = 1'b1;
                    n_out_byte = echo_byte(r_kind, r_pos, r_data);
                    n_out_line = 1'b0;
                    n_out_len  = '0;
                    n_out_last = (r_pos == w_elen - POS_W'(1)) && (r_len == '0);
                    if (r_pos == w_elen - POS_W'(1)) begin
                        n_state = (r_len == '0) ? S_IDLE : S_LINE;
                        n_idx   = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            S_LINE: begin
                if (w_adv) begin
                    w_load     = 1'b1;
                    // the newline closing a handed-over line is never in the store
                    n_out_byte = (r_is_line && w_body_end) ? CH_LF : r_rd_data;
                    n_out_line = r_is_line;
                    n_out_len  = r_is_line ? r_len : '0;
                    n_out_last = w_body_end;
                    if (w_body_end) n_state = S_IDLE;
                    else            n_idx   = r_idx + CNT_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_nzlen     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_nzlen <= n_nzlen;
            if (w_adv) r_out_valid <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_data     <= n_data;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_is_line  <= n_is_line;
        r_out_byte <= n_out_byte;
        r_out_line <= n_out_line;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_count[AW-1:0]] <= i_q_cmd.data;
        r_rd_data <= r_mem[n_idx[AW-1:0]];
    end

    assign o_valid   = r_out_valid;
    assign o_byte    = r_out_byte;
    assign o_is_line = r_out_line;
    assign o_length  = r_out_len;
    assign o_last    = r_out_last;

endmodule

// ===== sv/echoing_line_editor.sv =====
`timescale 1ns / 1ps
// channel    | direction | tdata                | tuser            | tlast
// -----------+-----------+----------------------+------------------+---------------------
// s (rx)     | in        | [7:0] rx_byte        | -                | -
// m (result) | out       | [7:0] out_byte,      | [0] is_line_byte | last result of the
//            |           | [13:8] line_length   |                  | received byte
//
// commands: the back end takes a command from the queue, then sends its results; a retype
//   also sends the stored line up to its first zero byte, a line hands over its bytes (up
//   to LINE_LEN); a dropped byte (backspace on an empty line, byte on a full line) gives no result
// reset: clears the count, the command queue and the output register, not the line store
// stalls: the two-entry queue takes bytes while the back end is busy; a stalled result
//   holds the back end in place
module echoing_line_editor
    import ele_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received byte transaction
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    // result transaction
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [7:0] out_byte, [13:8] line_length
    output logic                 o_m_tuser,   // [0] is_line_byte
    output logic                 o_m_tlast    // last result of one received byte
);

    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    t_cmd              w_front_cmd;
    t_cmd              w_back_cmd;
    logic [DATA_W-1:0] w_byte;
    logic              w_is_line;
    logic [CNT_W-1:0]  w_length;

    // front end: decode the received byte into a command
    ele_front u_front (
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_data   (i_s_tdata),
        .i_q_full (w_q_full),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    // decouples decoding from execution
    ele_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd)
    );

    // back end: owns the line store and sequences echo and line bytes
    ele_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_back_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (w_byte),
        .o_is_line (w_is_line),
        .o_length  (w_length),
        .o_last    (o_m_tlast)
    );

    // length rides above the byte, upper bits padded to a whole byte
    assign o_m_tdata = {{(M_TDATA_W - CNT_W - DATA_W){1'b0}}, w_length, w_byte};
    assign o_m_tuser = w_is_line;

endmodule

// ===== sv/ele_checker.sv =====
`timescale 1ns / 1ps
module ele_checker
    import ele_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser,
    input logic                 o_m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // the final byte of a handed-over line is the newline
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && o_m_tlast |-> o_m_tdata[DATA_W-1:0] == CH_LF)
        else $error("line did not end in newline");

    // echo bytes carry no length, line bytes always do
    a_echo_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[DATA_W+CNT_W-1:DATA_W] == '0)
        else $error("echo byte with nonzero length");

    a_line_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[DATA_W+CNT_W-1:DATA_W] != '0)
        else $error("line byte with zero length");

    // an echo byte never follows a non-final line byte
    a_line_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser && !o_m_tlast
        ##1 o_m_tvalid |-> o_m_tuser)
        else $error("line hand-over interrupted");

endmodule

bind echoing_line_editor ele_checker u_ele_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== sim/line_editor_checker.sv =====
`timescale 1ns / 1ps
module line_editor_checker
    import ele_pkg::*;
#(
    parameter int LINE_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [DATA_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // [7:0] out_byte, [13:8] line_length
    input  logic                 i_m_tuser,   // [0] is_line_byte
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] ch;
        logic              line_flag;
        logic [CNT_W-1:0]  line_len;
        logic              tail;
    } t_echo_item;

    t_echo_item        echo_q[$];
    t_echo_item        want;
    logic [DATA_W-1:0] line_buf [LINE_LEN];
    logic [CNT_W-1:0]  held;
    int                fails = 0;

    function automatic t_kind classify(input logic [DATA_W-1:0] b);
        if (b == CH_BS || b == CH_DEL)
            return K_BS;
        if (b == CH_RETYPE)
            return K_RETYPE;
        if (b == CH_KILL)
            return K_KILL;
        if (b == CH_LF || b == CH_CR)
            return K_NEWLINE;
        return K_CHAR;
    endfunction

    function automatic void add_echo(input logic [DATA_W-1:0] ch, input logic line_flag,
                                     input logic [CNT_W-1:0] line_len);
        t_echo_item e;
        e.ch        = ch;
        e.line_flag = line_flag;
        e.line_len  = line_len;
        e.tail      = 1'b0;
        echo_q.push_back(e);
    endfunction

    function automatic void wipe_line();
        for (int k = 0; k < LINE_LEN; k++)
            line_buf[k] = '0;
        held = '0;
    endfunction

    // edits the line for one received byte and queues every result it causes
    function automatic void edit_line(input logic [DATA_W-1:0] rx);
        int               before_n;
        logic [CNT_W-1:0] len;
        t_echo_item       e;
        before_n = echo_q.size();
        case (classify(rx))
            K_BS: begin
                if (held != '0) begin
                    add_echo(CH_BS, 1'b0, '0);
                    add_echo(CH_SP, 1'b0, '0);
                    add_echo(CH_BS, 1'b0, '0);
                    held = held - 1'b1;
                    line_buf[held] = '0;
                end
            end
            K_RETYPE: begin
                add_echo(CH_CR, 1'b0, '0);
                add_echo(CH_LF, 1'b0, '0);
                // retype stops at the first stored zero byte
                for (int k = 0; k < int'(held) && line_buf[k] != '0; k++)
                    add_echo(line_buf[k], 1'b0, '0);
            end
            K_KILL: begin
                add_echo(CH_X, 1'b0, '0);
                add_echo(CH_X, 1'b0, '0);
                add_echo(CH_X, 1'b0, '0);
                add_echo(CH_CR, 1'b0, '0);
                add_echo(CH_LF, 1'b0, '0);
                wipe_line();
            end
            K_NEWLINE: begin
                line_buf[held] = CH_LF;
                held = held + 1'b1;
                len = held;
                add_echo(CH_CR, 1'b0, '0);
                add_echo(CH_LF, 1'b0, '0);
                for (int k = 0; k < int'(len); k++)
                    add_echo(line_buf[k], 1'b1, len);
                wipe_line();
            end
            default: begin
                // full line drops the byte silently, room stays for the newline
                if (int'(held) < LINE_LEN - 1) begin
                    line_buf[held] = rx;
                    held = held + 1'b1;
                    add_echo(rx, 1'b0, '0);
                end
            end
        endcase
        if (echo_q.size() > before_n) begin
            e = echo_q.pop_back();
            e.tail = 1'b1;
            echo_q.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            echo_q.delete();
            wipe_line();
        end else begin
            // results first: a result never stems from a byte taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (echo_q.size() == 0) begin
                    $error("unexpected result: out_byte %0d", i_m_tdata[DATA_W-1:0]);
                    fails++;
                end else begin
                    want = echo_q.pop_front();
                    if (i_m_tdata[DATA_W-1:0] !== want.ch) begin
                        $error("out_byte: expected %0d, got %0d", want.ch,
                               i_m_tdata[DATA_W-1:0]);
                        fails++;
                    end
                    if (i_m_tuser !== want.line_flag) begin
                        $error("is_line_byte: expected %0d, got %0d",
                               want.line_flag, i_m_tuser);
                        fails++;
                    end
                    if (i_m_tdata[DATA_W+CNT_W-1:DATA_W] !== want.line_len) begin
                        $error("line_length: expected %0d, got %0d",
                               want.line_len, i_m_tdata[DATA_W+CNT_W-1:DATA_W]);
                        fails++;
                    end
                    if (i_m_tlast !== want.tail) begin
                        $error("last: expected %0d, got %0d", want.tail, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                edit_line(i_s_tdata);
        end
        o_fail_count <= fails;
        o_pending    <= echo_q.size();
    end

endmodule

// ===== sim/echoing_line_editor_test.sv =====
`timescale 1ns / 1ps
module echoing_line_editor_test;
    import ele_pkg::*;

    localparam int LINE_LEN     = 32;
    localparam int RANDOM_BYTES = 350;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata;   // [7:0] rx_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;   // [7:0] out_byte, [13:8] line_length
    logic                 o_m_tuser;   // [0] is_line_byte
    logic                 o_m_tlast;

    int fail_count;
    int pending;
    int bytes_sent;
    bit no_gap;

    echoing_line_editor #(
        .LINE_LEN (LINE_LEN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    line_editor_checker #(
        .LINE_LEN (LINE_LEN)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: ready runs broken by stalls, mostly short, now and then long
    initial begin
        int run;
        int stall;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
            i_m_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
            i_m_tready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gap)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a byte that the editor stores as text
    function automatic logic [DATA_W-1:0] pick_char();
        logic [DATA_W-1:0] c;
        do begin
            if ($urandom_range(0, 4) == 0)
                c = DATA_W'($urandom_range(0, 255));
            else
                c = DATA_W'($urandom_range(32, 126));
        end while (c == CH_BS || c == CH_DEL || c == CH_RETYPE || c == CH_KILL ||
                   c == CH_LF || c == CH_CR);
        return c;
    endfunction

    // one received byte transaction, valid held until taken
    task automatic send_byte(input logic [DATA_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // one typed line: text with edits, closed by a newline or a line kill;
    // some lines overrun the store, some are plain noise
    task automatic type_line(input bit force_full);
        int mode;
        int nchar;
        int r;
        mode = force_full ? 0 : $urandom_range(0, 99);
        if (mode >= 8 && mode < 20) begin
            repeat ($urandom_range(1, 6))
                send_byte(DATA_W'($urandom_range(0, 255)));
            return;
        end
        nchar = (mode < 8) ? $urandom_range(LINE_LEN - 3, LINE_LEN + 6)
                           : $urandom_range(0, 14);
        if (force_full)
            nchar = LINE_LEN + 2;
        for (int k = 0; k < nchar; k++) begin
            send_byte(pick_char());
            r = $urandom_range(0, 99);
            if (!force_full && r < 10)
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            else if (!force_full && r < 14)
                send_byte(CH_RETYPE);
        end
        // retype of a full line gives the longest echo
        if (mode < 8 && $urandom_range(0, 1) == 0)
            send_byte(CH_RETYPE);
        r = $urandom_range(0, 99);
        if (r < 12)
            send_byte(CH_KILL);
        else
            send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    initial begin
        int lines;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        no_gap     = 1'b0;
        bytes_sent = 0;
        lines      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // backspace and delete on an empty line do nothing
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(CH_RETYPE);
        // zero byte in the line cuts the retype short
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_RETYPE);
        send_byte(CH_DEL);
        send_byte(CH_BS);
        send_byte(CH_RETYPE);
        send_byte(CH_CR);
        // empty line still hands over its newline
        send_byte(CH_LF);
        send_byte(8'h7E);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(CH_KILL);
        send_byte(CH_KILL);
        // zero byte travels with the completed line
        send_byte(8'h00);
        send_byte(CH_CR);
        drain();
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(CH_LF);

        // random lines, the first one overruns the store
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            no_gap = ($urandom_range(0, 5) == 0);
            type_line(lines == 0);
            lines++;
            if (lines % 8 == 0)
                drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
